/* hw/rtl/biq_pkg.sv */
// shared constants, codes and command types of the biquad filter
`timescale 1ns / 1ps

package biq_pkg;

   // default widths and fixed-point format
   localparam int DEF_SAMPLE_WIDTH = 24;
   localparam int DEF_COEF_WIDTH   = 32;
   localparam int FRAC_BITS        = 28;

   // register map
   localparam int NUM_REGS      = 6;
   localparam int REG_NORM_GAIN = 0;
   localparam int REG_FF_COEF_0 = 1;
   localparam int REG_FF_COEF_1 = 2;
   localparam int REG_FF_COEF_2 = 3;
   localparam int REG_FB_COEF_1 = 4;
   localparam int REG_FB_COEF_2 = 5;

   // 1.0 in q4.28
   localparam logic [63:0] UNITY = 64'h0000_0000_1000_0000;

   // operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      SEL_X0,
      SEL_X1,
      SEL_X2,
      SEL_Y1,
      SEL_Y2,
      SEL_GAIN
   } mul_sel_type;

   // accumulator operation
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        load_in;
      acc_op_type  acc_op;
      mul_sel_type mul_sel;
      logic        finish;
   } cmd_type;

   // reset value of a coefficient register
   function automatic logic [63:0] coef_reset(input int idx);
      logic [63:0] val;
      val = '0;
      if (idx == REG_NORM_GAIN || idx == REG_FF_COEF_0) begin
         val = UNITY;
      end
      return val;
   endfunction

endpackage

/* hw/rtl/biq_csr.sv */
// coefficient register file behind the apb-style port
`timescale 1ns / 1ps

module biq_csr #(
   parameter int COEF_WIDTH = biq_pkg::DEF_COEF_WIDTH,
   parameter int CSR_DW     = 32,
   parameter int ADDR_W     = 5,
   parameter int ADDR_LSB   = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DW-1:0]     csr_pwdata,
   output logic [CSR_DW-1:0]     csr_prdata,
   output logic                  csr_pready,
   output logic [COEF_WIDTH-1:0] coef [biq_pkg::NUM_REGS]
);
   import biq_pkg::*;

   localparam int IDX_W = ADDR_W - ADDR_LSB;

   logic [COEF_WIDTH-1:0] coef_ff [NUM_REGS];
   logic [IDX_W-1:0]      idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[ADDR_W-1:ADDR_LSB];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register writes, indexes past the map are dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reset) begin
            coef_ff[i] <= COEF_WIDTH'(coef_reset(i));
         end else if (wr_en && idx == IDX_W'(i)) begin
            coef_ff[i] <= csr_pwdata[COEF_WIDTH-1:0];
         end
      end
   end

   // read back, sign extended
   always_comb begin
      csr_prdata = '0;
      if (idx < IDX_W'(NUM_REGS)) begin
         csr_prdata = CSR_DW'(signed'(coef_ff[idx]));
      end
   end

   assign coef = coef_ff;

endmodule

/* hw/rtl/biq_ctrl.sv */
// sequencer for the shared multiply-accumulate datapath
`timescale 1ns / 1ps

module biq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output biq_pkg::cmd_type cmd
);
   import biq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_ACC,
      ST_GAIN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // commands and next state
   always_comb begin
      cmd          = '{load_in: 1'b0, acc_op: ACC_HOLD, mul_sel: SEL_X0, finish: 1'b0};
      state_in     = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               cmd.acc_op  = ACC_CLEAR;
               state_in    = ST_MUL0;
            end
         end
         ST_MUL0: begin
            cmd.mul_sel = SEL_X0;
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_sel = SEL_X1;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_sel = SEL_X2;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul_sel = SEL_Y1;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.mul_sel = SEL_Y2;
            cmd.acc_op  = ACC_SUB;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_op = ACC_SUB;
            state_in   = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.mul_sel = SEL_GAIN;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            // keep the gain product steady while the output stalls
            cmd.mul_sel = SEL_GAIN;
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a finished word never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten while stalled");

   // a finished word is offered in the next cycle
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished word not offered");

   // one word at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while busy");

   // the accumulator is cleared only on an accept
   a_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc_op == ACC_CLEAR) |-> (cmd.load_in && req_tvalid && req_tready))
      else $error("accumulator cleared outside an accept");
`endif

endmodule

/* hw/rtl/biq_datapath.sv */
// history, shared multiplier, accumulator, gain and saturation
`timescale 1ns / 1ps

module biq_datapath #(
   parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = biq_pkg::DEF_COEF_WIDTH,
   parameter int TDATA_WIDTH  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [TDATA_WIDTH-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic [COEF_WIDTH-1:0]  coef [biq_pkg::NUM_REGS],
   input  biq_pkg::cmd_type       cmd,
   output logic [TDATA_WIDTH-1:0] rsp_tdata,
   output logic                   rsp_tlast
);
   import biq_pkg::*;

   localparam int ACC_W = SAMPLE_WIDTH + COEF_WIDTH + 3;
   localparam int SH_W  = (ACC_W > FRAC_BITS) ? ACC_W - FRAC_BITS : 1;
   localparam int MA_W  = (SH_W > SAMPLE_WIDTH) ? SH_W : SAMPLE_WIDTH;
   localparam int P_W   = MA_W + COEF_WIDTH;
   localparam int EXT_W = (P_W > ACC_W) ? P_W : ACC_W;

   localparam logic signed [P_W-1:0] SMAX =
      signed'({{(P_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [P_W-1:0] SMIN = ~SMAX;

   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [SAMPLE_WIDTH-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic                           last_ff, last_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [P_W-1:0]          prod_ff, prod_in;
   logic [TDATA_WIDTH-1:0]         rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic signed [MA_W-1:0]         op_a;
   logic signed [COEF_WIDTH-1:0]   op_b;
   logic signed [ACC_W-1:0]        acc_shift;
   logic signed [SH_W-1:0]         acc_sh;
   logic signed [EXT_W-1:0]        prod_ext;
   logic signed [ACC_W-1:0]        prod_acc;
   logic signed [P_W-1:0]          fin;
   logic [SAMPLE_WIDTH-1:0]        y_bits;

   // accumulator scaled down before the gain multiply
   assign acc_shift = acc_ff >>> FRAC_BITS;
   assign acc_sh    = signed'(acc_shift[SH_W-1:0]);

   // tap product sized to the accumulator
   assign prod_ext = EXT_W'(prod_ff);
   assign prod_acc = signed'(prod_ext[ACC_W-1:0]);

   // gain product scaled down and saturated
   assign fin = prod_ff >>> FRAC_BITS;
   always_comb begin
      if (fin > SMAX) begin
         y_bits = SMAX[SAMPLE_WIDTH-1:0];
      end else if (fin < SMIN) begin
         y_bits = SMIN[SAMPLE_WIDTH-1:0];
      end else begin
         y_bits = fin[SAMPLE_WIDTH-1:0];
      end
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         SEL_X0: begin
            op_a = MA_W'(x_ff);
            op_b = signed'(coef[REG_FF_COEF_0]);
         end
         SEL_X1: begin
            op_a = MA_W'(x1_ff);
            op_b = signed'(coef[REG_FF_COEF_1]);
         end
         SEL_X2: begin
            op_a = MA_W'(x2_ff);
            op_b = signed'(coef[REG_FF_COEF_2]);
         end
         SEL_Y1: begin
            op_a = MA_W'(y1_ff);
            op_b = signed'(coef[REG_FB_COEF_1]);
         end
         SEL_Y2: begin
            op_a = MA_W'(y2_ff);
            op_b = signed'(coef[REG_FB_COEF_2]);
         end
         SEL_GAIN: begin
            op_a = MA_W'(acc_sh);
            op_b = signed'(coef[REG_NORM_GAIN]);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // next values
   always_comb begin
      prod_in     = op_a * op_b;
      x_in        = x_ff;
      last_in     = last_ff;
      x1_in       = x1_ff;
      x2_in       = x2_ff;
      y1_in       = y1_ff;
      y2_in       = y2_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;

      case (cmd.acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + prod_acc;
         ACC_SUB:   acc_in = acc_ff - prod_acc;
         default:   acc_in = acc_ff;
      endcase

      if (cmd.load_in) begin
         x_in    = signed'(req_tdata[SAMPLE_WIDTH-1:0]);
         last_in = req_tlast;
      end

      // result out, history shifts
      if (cmd.finish) begin
         rsp_data_in = TDATA_WIDTH'(y_bits);
         rsp_last_in = last_ff;
         x2_in       = x1_ff;
         x1_in       = x_ff;
         y2_in       = y1_ff;
         y1_in       = signed'(y_bits);
      end
   end

   // history state
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

/* hw/rtl/biquad_iir_filter_unit.sv */
// top level of the direct form i biquad filter
//
//   channel  direction  handshake            payload
//   req_     in         tvalid / tready      tdata: sample_in, tlast: last_in
//   rsp_     out        tvalid / tready      tdata: sample_out, tlast: last_out
//   csr_     in         apb, pready high     coefficient registers at 4*i, 8*i when COEF_WIDTH > 32
//
// a word passes from accept to output register in steps: five tap products and
// one gain product share a single registered multiplier, stepped by the
// sequencer, plus a step for the last tap sum and a saturate step.
// a new word is taken only in idle, after the previous word has finished its steps.
// the next word is accepted as soon as the sequencer is back in idle, even
// while the previous result still waits in the output register.
// a stalled output holds the final step until the waiting word is taken.
// reset is synchronous; it restores the coefficients and clears the history.
`timescale 1ns / 1ps

module biquad_iir_filter_unit #(
   parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = biq_pkg::DEF_COEF_WIDTH,
   parameter int TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8,
   parameter int CSR_DW       = (COEF_WIDTH > 32) ? 64 : 32,
   parameter int ADDR_LSB     = (COEF_WIDTH > 32) ? 3 : 2,
   parameter int ADDR_W       = $clog2(biq_pkg::NUM_REGS << ADDR_LSB)
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample_in [SAMPLE_WIDTH-1:0], zero pad above
   input  logic [TDATA_WIDTH-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // sample_out [SAMPLE_WIDTH-1:0], zero pad above
   output logic [TDATA_WIDTH-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);
   import biq_pkg::*;

   logic [COEF_WIDTH-1:0] coef [NUM_REGS];
   cmd_type               cmd;

   // coefficient registers
   biq_csr #(
      .COEF_WIDTH (COEF_WIDTH),
      .CSR_DW     (CSR_DW),
      .ADDR_W     (ADDR_W),
      .ADDR_LSB   (ADDR_LSB)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // sequencer
   biq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // arithmetic and history
   biq_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH),
      .TDATA_WIDTH  (TDATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .coef      (coef),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

/* sim/biquad_iir_filter_unit_tb.sv */
// self-checking testbench of the biquad filter unit: stream words in, compare filtered words out
`timescale 1ns / 1ps

module biquad_iir_filter_unit_tb;

   localparam int SW      = biq_pkg::DEF_SAMPLE_WIDTH;
   localparam int CW      = biq_pkg::DEF_COEF_WIDTH;
   localparam int CSR_AW  = $clog2(biq_pkg::NUM_REGS << 2);
   localparam int ADDR_SH = 2;

   localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [127:0] SAT_HI = 128'sd8388607;
   localparam logic signed [127:0] SAT_LO = -128'sd8388608;

   localparam logic [CW-1:0] Q_ONE     = biq_pkg::UNITY[CW-1:0];
   localparam logic [CW-1:0] Q_TWO     = 32'h2000_0000;
   localparam logic [CW-1:0] Q_HALF    = 32'h0800_0000;
   localparam logic [CW-1:0] Q_NHALF   = 32'hF800_0000;
   localparam logic [CW-1:0] Q_NONE    = 32'hF000_0000;
   localparam logic [CW-1:0] COEF_MAX  = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] COEF_MIN  = 32'h8000_0000;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_PERIODIC
   } stall_mode_type;

   typedef struct {
      logic [SW-1:0] sample;
      logic          last;
   } audio_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [SW-1:0]     req_tdata   = '0;   // sample_in [23:0]
   logic              req_tlast   = 1'b0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [SW-1:0]     rsp_tdata;          // sample_out [23:0]
   logic              rsp_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CW-1:0]     csr_pwdata  = '0;
   logic [CW-1:0]     csr_prdata;
   logic              csr_pready;

   biquad_iir_filter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // filter model: coefficient copies and history
   logic signed [CW-1:0] coef_regs [biq_pkg::NUM_REGS];
   logic signed [SW-1:0] x_d1 = '0, x_d2 = '0, y_d1 = '0, y_d2 = '0;

   audio_word_type pending_q  [$];
   audio_word_type filtered_q [$];

   int err_count      = 0;
   int accepted_count = 0;
   int result_count   = 0;
   int setting_count  = 0;
   int sat_hi_count   = 0;
   int sat_lo_count   = 0;

   // one filter step: exact taps, floor shifts, saturation, history update
   function automatic logic [SW-1:0] filter_step(input logic signed [SW-1:0] x);
      logic signed [127:0] g, b0, b1, b2, a1, a2;
      logic signed [127:0] wx, wx1, wx2, wy1, wy2, acc;
      logic signed [SW-1:0] y;
      g   = coef_regs[biq_pkg::REG_NORM_GAIN];
      b0  = coef_regs[biq_pkg::REG_FF_COEF_0];
      b1  = coef_regs[biq_pkg::REG_FF_COEF_1];
      b2  = coef_regs[biq_pkg::REG_FF_COEF_2];
      a1  = coef_regs[biq_pkg::REG_FB_COEF_1];
      a2  = coef_regs[biq_pkg::REG_FB_COEF_2];
      wx  = x;
      wx1 = x_d1;
      wx2 = x_d2;
      wy1 = y_d1;
      wy2 = y_d2;
      acc = b0 * wx + b1 * wx1 + b2 * wx2 - (a1 * wy1 + a2 * wy2);
      acc = acc >>> biq_pkg::FRAC_BITS;
      acc = acc * g;
      acc = acc >>> biq_pkg::FRAC_BITS;
      if (acc > SAT_HI) begin
         y = SAMPLE_MAX;
         sat_hi_count++;
      end else if (acc < SAT_LO) begin
         y = SAMPLE_MIN;
         sat_lo_count++;
      end else begin
         y = acc[SW-1:0];
      end
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = y;
      return y;
   endfunction

   // driver: bursts of random length from the pending queue, random gaps between
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      audio_word_type held_word;
      audio_word_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            want.sample = filter_step(req_tdata);
            want.last   = req_tlast;
            filtered_q.push_back(want);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               held_word = pending_q.pop_front();
               req_tdata  <= held_word.sample;
               req_tlast  <= held_word.last;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  // long stretch with no idling
                  burst_left = $urandom_range(30, 80);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = $urandom_range(1, 15);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   stall_mode_type stall_mode = RDY_ALWAYS;
   int             mode_left  = 0;
   int             stall_cyc  = 0;
   always @(posedge clock) begin
      audio_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (filtered_q.size() == 0) begin
               err_count++;
               $display("%0t: unexpected word sample %h last %b", $time, rsp_tdata, rsp_tlast);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata !== want.sample) begin
                  err_count++;
                  $display("%0t: sample_out expected %h actual %h", $time, want.sample,
                           rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  err_count++;
                  $display("%0t: last_out expected %b actual %b", $time, want.last, rsp_tlast);
               end
            end
         end
         // stall pattern switches to a random mode when its hold count runs out
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         stall_cyc++;
         case (stall_mode)
            RDY_ALWAYS:   rsp_tready <= 1'b1;
            RDY_COIN:     rsp_tready <= $urandom_range(0, 1);
            RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
            default:      rsp_tready <= (stall_cyc % 5 != 0);
         endcase
      end
   end

   // apb write, register updated at the access edge
   task automatic csr_write(input int idx, input logic [CW-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(idx << ADDR_SH);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx < biq_pkg::NUM_REGS) begin
         coef_regs[idx] = data;
      end
   endtask

   // read back every coefficient register and compare
   task automatic csr_check_all();
      for (int idx = 0; idx < biq_pkg::NUM_REGS; idx++) begin
         @(posedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= CSR_AW'(idx << ADDR_SH);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== coef_regs[idx]) begin
            err_count++;
            $display("%0t: register %0d read expected %h actual %h", $time, idx,
                     coef_regs[idx], csr_prdata);
         end
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   task automatic apply_config(input logic [CW-1:0] gain, input logic [CW-1:0] b0,
                               input logic [CW-1:0] b1, input logic [CW-1:0] b2,
                               input logic [CW-1:0] a1, input logic [CW-1:0] a2);
      csr_write(biq_pkg::REG_NORM_GAIN, gain);
      csr_write(biq_pkg::REG_FF_COEF_0, b0);
      csr_write(biq_pkg::REG_FF_COEF_1, b1);
      csr_write(biq_pkg::REG_FF_COEF_2, b2);
      csr_write(biq_pkg::REG_FB_COEF_1, a1);
      csr_write(biq_pkg::REG_FB_COEF_2, a2);
      csr_check_all();
      setting_count++;
   endtask

   task automatic queue_sample(input logic [SW-1:0] sample, input logic last);
      audio_word_type w;
      w.sample = sample;
      w.last   = last;
      pending_q.push_back(w);
   endtask

   // wait until the block has nothing in flight
   task automatic drain_filter();
      @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || filtered_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [CW-1:0] coef_near(input int unsigned mag);
      return CW'($urandom_range(0, 2 * mag)) - CW'(mag);
   endfunction

   function automatic logic [CW-1:0] coef_extreme();
      case ($urandom_range(0, 5))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return '0;
         3:       return Q_ONE;
         4:       return Q_NONE;
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic logic [SW-1:0] random_sample();
      case ($urandom_range(0, 19))
         0, 1:     return SAMPLE_MAX;
         2, 3:     return SAMPLE_MIN;
         4:        return '0;
         5:        return '1;
         6, 7, 8:  return SW'($urandom_range(0, 4000)) - SW'(2000);
         default:  return SW'($urandom);
      endcase
   endfunction

   // reset, then directed and random phases
   initial begin
      int n_items;
      for (int idx = 0; idx < biq_pkg::NUM_REGS; idx++) begin
         coef_regs[idx] = '0;
      end
      coef_regs[biq_pkg::REG_NORM_GAIN] = Q_ONE;
      coef_regs[biq_pkg::REG_FF_COEF_0] = Q_ONE;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values, pass-through filter
      csr_check_all();
      @(negedge clock);
      queue_sample('0, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample('1, 1'b0);
      queue_sample(SW'(1), 1'b1);
      queue_sample(24'h555555, 1'b0);
      queue_sample(24'hAAAAAA, 1'b1);
      drain_filter();

      // gain of two: saturation at both ends and the exact negative limit
      apply_config(Q_TWO, Q_ONE, '0, '0, '0, '0);
      @(negedge clock);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      queue_sample(24'h3FFFFF, 1'b0);
      queue_sample(24'hC00000, 1'b0);
      queue_sample(24'h400000, 1'b1);
      drain_filter();

      // half taps with feedback: floor rounding of negatives, saturated history
      apply_config(Q_ONE, Q_HALF, '0, '0, Q_NHALF, '0);
      @(negedge clock);
      queue_sample('1, 1'b0);
      queue_sample('1, 1'b0);
      queue_sample(SW'(1), 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      drain_filter();

      // every coefficient at its positive and its negative limit
      apply_config(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      @(negedge clock);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      drain_filter();
      apply_config(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      @(negedge clock);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      drain_filter();

      // random phases, each with its own coefficient set
      for (int phase = 0; phase < 12; phase++) begin
         // writes above the register map must be ignored
         if ($urandom_range(0, 2) == 0) begin
            csr_write(biq_pkg::NUM_REGS, CW'($urandom));
            csr_write(biq_pkg::NUM_REGS + 1, CW'($urandom));
         end
         case (phase % 4)
            0: apply_config(CW'($urandom), CW'($urandom), CW'($urandom),
                            CW'($urandom), CW'($urandom), CW'($urandom));
            1: apply_config(coef_near(32'h1800_0000), coef_near(32'h1000_0000),
                            coef_near(32'h1000_0000), coef_near(32'h1000_0000),
                            coef_near(32'h2000_0000), coef_near(32'h1000_0000));
            2: apply_config(coef_extreme(), coef_extreme(), coef_extreme(),
                            coef_extreme(), coef_extreme(), coef_extreme());
            default: apply_config(Q_ONE, coef_near(32'h0400_0000), coef_near(32'h0400_0000),
                                  coef_near(32'h0400_0000), coef_near(32'h0400_0000),
                                  coef_near(32'h0400_0000));
         endcase
         @(negedge clock);
         n_items = $urandom_range(90, 125);
         for (int i = 0; i < n_items; i++) begin
            queue_sample(random_sample(), ($urandom_range(0, 7) == 0));
         end
         drain_filter();
      end

      repeat (32) @(posedge clock);
      $display("ran %0d samples through %0d coefficient settings, %0d results checked",
               accepted_count, setting_count, result_count);
      $display("outputs clipped high %0d times, low %0d times", sat_hi_count, sat_lo_count);
      if (err_count == 0) begin
         $display("biquad_iir_filter_unit_tb: clean");
      end else begin
         $display("biquad_iir_filter_unit_tb: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("biquad_iir_filter_unit_tb: errors");
      $finish;
   end

endmodule
